### rtl/rlcs_pkg.sv
package rlcs_pkg;

   localparam int unsigned TICK_W    = 16;
   localparam int unsigned PERIOD_W  = 8;
   localparam int unsigned LED_W     = 11;
   localparam int unsigned COLOR_W   = 24;
   localparam int unsigned BIT_IDX_W = 5;
   localparam int unsigned PHASE_W   = 2;
   localparam int unsigned CMD_W     = 2;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;

   // Longest chain that fill and clear will drive
   localparam int unsigned MAX_LEDS = 1024;

   // Bits in one LED word, green/red/blue
   localparam int unsigned BITS_PER_LED = 24;

   // Commands
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEND  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

   // Sequencer phases
   localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_BITS  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_LATCH = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_PERIOD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LATCH_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_COUNT  = 3'd4;

   // Register reset values
   localparam logic [PERIOD_W-1:0] RST_ZERO_HIGH  = 8'd18;
   localparam logic [PERIOD_W-1:0] RST_ONE_HIGH   = 8'd45;
   localparam logic [PERIOD_W-1:0] RST_BIT_PERIOD = 8'd63;
   localparam logic [TICK_W-1:0]   RST_LATCH_LOW  = 16'd2500;
   localparam logic [LED_W-1:0]    RST_LED_COUNT  = 11'd8;

   typedef struct packed {
      logic [PERIOD_W-1:0] zero_high_ticks;
      logic [PERIOD_W-1:0] one_high_ticks;
      logic [PERIOD_W-1:0] bit_period_ticks;
      logic [TICK_W-1:0]   latch_low_ticks;
      logic [LED_W-1:0]    led_count;
   } csr_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic rejected;
   } result_type;

endpackage

### rtl/rlcs_engine.sv
module rlcs_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  rlcs_pkg::csr_type            csr,
   input  logic [rlcs_pkg::CMD_W-1:0]   cmd,
   input  logic [7:0]                   red,
   input  logic [7:0]                   green,
   input  logic [7:0]                   blue,
   output rlcs_pkg::result_type         result
);
   import rlcs_pkg::*;

   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   logic [BIT_IDX_W-1:0] bit_idx_ff, bit_idx_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [LED_W-1:0]     leds_ff, leds_in;
   logic                 latch_ff, latch_in;

   always_comb begin
      logic [PHASE_W-1:0]   ph;
      logic [LED_W-1:0]     n_leds;
      logic [PERIOD_W-1:0]  period;
      logic [BIT_IDX_W-1:0] bi;
      logic                 cur_bit;
      logic [PERIOD_W-1:0]  high;
      logic [TICK_W:0]      tick_sum;
      logic [BIT_IDX_W:0]   bit_sum;
      logic                 starting;

      ph         = (phase_ff == PH_BITS || phase_ff == PH_LATCH) ? phase_ff : PH_IDLE;
      color_in   = color_ff;
      bit_idx_in = bit_idx_ff;
      tick_in    = tick_ff;
      leds_in    = leds_ff;
      latch_in   = latch_ff;
      result     = '0;

      starting        = (cmd != CMD_TICK) && (ph == PH_IDLE);
      result.rejected = (cmd != CMD_TICK) && (ph != PH_IDLE);

      n_leds = (17'(csr.led_count) > 17'(MAX_LEDS)) ? LED_W'(MAX_LEDS) : csr.led_count;

      if (starting) begin
         color_in   = (cmd == CMD_CLEAR) ? '0 : {green, red, blue};
         bit_idx_in = '0;
         tick_in    = '0;
         leds_in    = (cmd == CMD_SEND) ? LED_W'(1) : n_leds;
         latch_in   = (cmd != CMD_SEND);
         if (leds_in == '0) begin
            ph = (latch_in && csr.latch_low_ticks != '0) ? PH_LATCH : PH_IDLE;
         end else begin
            ph = PH_BITS;
         end
      end

      period   = (csr.bit_period_ticks == '0) ? PERIOD_W'(1) : csr.bit_period_ticks;
      bi       = (bit_idx_in > BIT_IDX_W'(BITS_PER_LED - 1)) ?
                 BIT_IDX_W'(BITS_PER_LED - 1) : bit_idx_in;
      cur_bit  = color_in[BIT_IDX_W'(BITS_PER_LED - 1) - bi];
      high     = cur_bit ? csr.one_high_ticks : csr.zero_high_ticks;
      tick_sum = {1'b0, tick_in} + (TICK_W+1)'(1);
      bit_sum  = {1'b0, bit_idx_in} + (BIT_IDX_W+1)'(1);

      unique case (ph)
         PH_BITS: begin
            result.line_level = (tick_in < TICK_W'(high));
            result.busy_res   = 1'b1;
            if (tick_sum >= (TICK_W+1)'(period)) begin
               tick_in = '0;
               if (bit_sum >= (BIT_IDX_W+1)'(BITS_PER_LED)) begin
                  bit_idx_in = '0;
                  if (leds_in != '0) begin
                     leds_in = leds_in - LED_W'(1);
                  end
                  if (leds_in == '0) begin
                     // end of the last word: latch or go idle
                     ph = (latch_in && csr.latch_low_ticks != '0) ? PH_LATCH : PH_IDLE;
                  end
               end else begin
                  bit_idx_in = bit_sum[BIT_IDX_W-1:0];
               end
            end else begin
               tick_in = tick_sum[TICK_W-1:0];
            end
         end
         PH_LATCH: begin
            result.busy_res = 1'b1;
            if (tick_sum >= (TICK_W+1)'(csr.latch_low_ticks)) begin
               tick_in = '0;
               ph      = PH_IDLE;
            end else begin
               tick_in = tick_sum[TICK_W-1:0];
            end
         end
         default: begin
         end
      endcase

      phase_in = ph;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         color_ff   <= '0;
         bit_idx_ff <= '0;
         tick_ff    <= '0;
         leds_ff    <= '0;
         latch_ff   <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         color_ff   <= color_in;
         bit_idx_ff <= bit_idx_in;
         tick_ff    <= tick_in;
         leds_ff    <= leds_in;
         latch_ff   <= latch_in;
      end
   end

endmodule

### rtl/rgb_led_chain_serializer.sv
// One-wire RGB LED chain serializer.
//
// Input channel (req_*): one item per waveform tick. req_cmd selects tick
// only, send one LED, fill the chain or clear the chain; req_red/green/blue
// give the color for send and fill. Each LED word goes out green, red, blue,
// MSB first, each bit high for the zero or one high time and low for the
// rest of the bit period. Fill and clear finish with the latch low time.
// A command that arrives while a transfer runs is dropped and flagged.
//
// Result channel (rsp_*): exactly one item per input item, in order, with
// the line level, busy flag and rejected flag of that tick.
// Each result is registered in the output register, or in the skid when stalled.
// Throughput: one item per cycle while req_ready is high, set by the sequencer step in rlcs_engine.
// A two-entry output (result register plus skid) takes one more item when
// rsp_ready drops; that item waits in the skid and holds req_ready low until
// the cycle after the receiver takes the stalled result.
// Reset: synchronous; registers return to their defaults, the sequencer
// goes idle and both output entries empty. csr_* writes apply at once.
module rgb_led_chain_serializer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rlcs_pkg::CMD_W-1:0]       req_cmd,
   input  logic [7:0]                       req_red,
   input  logic [7:0]                       req_green,
   input  logic [7:0]                       req_blue,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_line_level,
   output logic                             rsp_busy_res,
   output logic                             rsp_rejected,
   input  logic                             csr_we,
   input  logic [rlcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rlcs_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import rlcs_pkg::*;

   csr_type    csr_ff;
   result_type step_res;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       accept;

   // Configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.zero_high_ticks  <= RST_ZERO_HIGH;
         csr_ff.one_high_ticks   <= RST_ONE_HIGH;
         csr_ff.bit_period_ticks <= RST_BIT_PERIOD;
         csr_ff.latch_low_ticks  <= RST_LATCH_LOW;
         csr_ff.led_count        <= RST_LED_COUNT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ZERO_HIGH:  csr_ff.zero_high_ticks  <= csr_wdata[PERIOD_W-1:0];
            CSR_ONE_HIGH:   csr_ff.one_high_ticks   <= csr_wdata[PERIOD_W-1:0];
            CSR_BIT_PERIOD: csr_ff.bit_period_ticks <= csr_wdata[PERIOD_W-1:0];
            CSR_LATCH_LOW:  csr_ff.latch_low_ticks  <= csr_wdata[TICK_W-1:0];
            CSR_LED_COUNT:  csr_ff.led_count        <= csr_wdata[LED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Take an item whenever the skid entry is free
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   rlcs_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .csr    (csr_ff),
      .cmd    (req_cmd),
      .red    (req_red),
      .green  (req_green),
      .blue   (req_blue),
      .result (step_res)
   );

   // Output register with skid: drain skid first, otherwise load the new result;
   // park the new result in the skid when the output is stalled.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = step_res;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = step_res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_line_level = out_ff.line_level;
   assign rsp_busy_res   = out_ff.busy_res;
   assign rsp_rejected   = out_ff.rejected;

endmodule

### rtl/rlcs_checker.sv
module rlcs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_line_level,
   input logic                             rsp_busy_res,
   input logic                             rsp_rejected
);

   // a dropped command only happens mid-transfer
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res)
      else $error("rejected item reported while idle");

   // the line is never driven high while idle
   a_level_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_level |-> rsp_busy_res)
      else $error("line high while idle");

   // input stalls only with both output entries full
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_level)
         && $stable(rsp_busy_res) && $stable(rsp_rejected))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output not empty after reset");

endmodule

bind rgb_led_chain_serializer rlcs_checker u_rlcs_checker (.*);

### test/rgb_led_chain_serializer_test.sv
`timescale 1ns / 100ps

module rgb_led_chain_serializer_test;
   import rlcs_pkg::*;

   // Watchdog: cycles with no item moving on either channel before giving up
   localparam int unsigned STALL_LIMIT  = 1000;
   // Receiver hold-off that lets the output entries fill and stall the input
   localparam int unsigned LONG_HOLD    = 80;
   localparam int unsigned HOLD_EVERY   = 700;
   localparam int unsigned RANDOM_ITEMS = 400;
   localparam int unsigned END_WAIT     = 20;
   localparam int unsigned MAX_REPORTS  = 20;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
   } tick_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_cmd = CMD_TICK;
   logic [7:0]           req_red = 8'd0;
   logic [7:0]           req_green = 8'd0;
   logic [7:0]           req_blue = 8'd0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_line_level;
   logic                 rsp_busy_res;
   logic                 rsp_rejected;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ZERO_HIGH;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   rgb_led_chain_serializer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_level (rsp_line_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_rejected   (rsp_rejected),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Items waiting to be offered, and line states predicted for items taken
   tick_item_type pending_items[$];
   result_type    expected_ticks[$];

   // Shadow of the register file, updated at the same edge as the block's
   csr_type csr_shadow;

   // Predicted sequencer state
   logic [PHASE_W-1:0]   seq_phase;
   logic [COLOR_W-1:0]   color_word;
   logic [BIT_IDX_W-1:0] bit_pos;
   logic [TICK_W-1:0]    tick_count;
   logic [LED_W-1:0]     leds_left;
   logic                 latch_pending;

   int unsigned mismatches     = 0;
   int unsigned ticks_checked  = 0;
   int unsigned commands_sent  = 0;
   int unsigned busy_drops     = 0;
   int unsigned reg_writes     = 0;
   int unsigned items_queued   = 0;
   int unsigned directed_items = 0;
   int unsigned stall_cycles   = 0;

   // Stretches with no idling on either side alternate with gappy stretches
   bit          calm = 1'b0;
   int unsigned calm_left = 0;

   always @(posedge clock) begin
      if (calm_left == 0) begin
         calm      <= ($urandom_range(0, 2) == 0);
         calm_left <= $urandom_range(30, 200);
      end else begin
         calm_left <= calm_left - 1;
      end
   end

   function automatic int unsigned draw_wait();
      return calm ? 0 : $urandom_range(0, 7);
   endfunction

   // ------------------------------------------------------------------
   // Line-state predictor
   // ------------------------------------------------------------------

   // After the last bit: enter the latch only for fill/clear with a latch time
   function automatic void end_led_words();
      if (latch_pending && csr_shadow.latch_low_ticks != '0) begin
         seq_phase  = PH_LATCH;
         tick_count = '0;
      end else begin
         seq_phase = PH_IDLE;
      end
   endfunction

   // Advance the sequencer by one tick and return the line state of that tick
   function automatic result_type predict_tick(input logic [CMD_W-1:0] cmd,
                                               input logic [7:0] red,
                                               input logic [7:0] green,
                                               input logic [7:0] blue);
      result_type           res;
      logic [LED_W-1:0]     chain_len;
      logic [PERIOD_W-1:0]  period;
      logic [PERIOD_W-1:0]  high_ticks;
      logic [BIT_IDX_W-1:0] bi;
      logic                 cur_bit;
      res = '0;
      if (seq_phase != PH_BITS && seq_phase != PH_LATCH) seq_phase = PH_IDLE;

      // A command while busy is dropped, but the tick still advances
      if (cmd != CMD_TICK) begin
         if (seq_phase != PH_IDLE) begin
            res.rejected = 1'b1;
         end else begin
            chain_len = (csr_shadow.led_count > LED_W'(MAX_LEDS)) ?
                        LED_W'(MAX_LEDS) : csr_shadow.led_count;
            color_word = (cmd == CMD_CLEAR) ? '0 : {green, red, blue};
            bit_pos    = '0;
            tick_count = '0;
            if (cmd == CMD_SEND) begin
               leds_left     = LED_W'(1);
               latch_pending = 1'b0;
            end else begin
               leds_left     = chain_len;
               latch_pending = 1'b1;
            end
            if (leds_left == '0) end_led_words();
            else seq_phase = PH_BITS;
         end
      end

      if (seq_phase == PH_BITS) begin
         period     = (csr_shadow.bit_period_ticks == '0) ?
                      PERIOD_W'(1) : csr_shadow.bit_period_ticks;
         bi         = (bit_pos > 5'd23) ? 5'd23 : bit_pos;
         cur_bit    = color_word[5'd23 - bi];
         high_ticks = cur_bit ? csr_shadow.one_high_ticks : csr_shadow.zero_high_ticks;
         res.line_level = (tick_count < {8'd0, high_ticks});
         res.busy_res   = 1'b1;
         tick_count = tick_count + 16'd1;
         if (tick_count >= {8'd0, period}) begin
            tick_count = '0;
            bit_pos    = bit_pos + 5'd1;
            if (bit_pos >= 5'd24) begin
               bit_pos = '0;
               if (leds_left != '0) leds_left = leds_left - 11'd1;
               if (leds_left == '0) end_led_words();
            end
         end
      end else if (seq_phase == PH_LATCH) begin
         res.busy_res = 1'b1;
         tick_count   = tick_count + 16'd1;
         if (tick_count >= csr_shadow.latch_low_ticks) begin
            tick_count = '0;
            seq_phase  = PH_IDLE;
         end
      end
      return res;
   endfunction

   // Mirror register writes; the block applies them at the same edge
   always @(posedge clock) begin
      if (reset) begin
         csr_shadow.zero_high_ticks  <= RST_ZERO_HIGH;
         csr_shadow.one_high_ticks   <= RST_ONE_HIGH;
         csr_shadow.bit_period_ticks <= RST_BIT_PERIOD;
         csr_shadow.latch_low_ticks  <= RST_LATCH_LOW;
         csr_shadow.led_count        <= RST_LED_COUNT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ZERO_HIGH:  csr_shadow.zero_high_ticks  <= csr_wdata[PERIOD_W-1:0];
            CSR_ONE_HIGH:   csr_shadow.one_high_ticks   <= csr_wdata[PERIOD_W-1:0];
            CSR_BIT_PERIOD: csr_shadow.bit_period_ticks <= csr_wdata[PERIOD_W-1:0];
            CSR_LATCH_LOW:  csr_shadow.latch_low_ticks  <= csr_wdata[TICK_W-1:0];
            CSR_LED_COUNT:  csr_shadow.led_count        <= csr_wdata[LED_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Driver: offer pending items, predict each one as it is taken
   // ------------------------------------------------------------------
   int unsigned req_gap = 0;

   always @(posedge clock) begin : drive_req
      tick_item_type next_item;
      int unsigned   gap;
      if (reset) begin
         req_valid     <= 1'b0;
         req_gap       <= 0;
         seq_phase     = PH_IDLE;
         color_word    = '0;
         bit_pos       = '0;
         tick_count    = '0;
         leds_left     = '0;
         latch_pending = 1'b0;
      end else if (req_valid && req_ready) begin
         expected_ticks.push_back(predict_tick(req_cmd, req_red, req_green, req_blue));
         if (req_cmd != CMD_TICK) commands_sent++;
         if (expected_ticks[$].rejected) busy_drops++;
         // Keep valid high for a back-to-back item, else drop it for the gap
         gap = draw_wait();
         if (gap == 0 && pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            req_cmd   <= next_item.cmd;
            req_red   <= next_item.red;
            req_green <= next_item.green;
            req_blue  <= next_item.blue;
         end else begin
            req_valid <= 1'b0;
            req_gap   <= (gap == 0) ? 0 : gap - 1;
         end
      end else if (!req_valid) begin
         if (req_gap != 0) begin
            req_gap <= req_gap - 1;
         end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            req_cmd   <= next_item.cmd;
            req_red   <= next_item.red;
            req_green <= next_item.green;
            req_blue  <= next_item.blue;
            req_valid <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each result with the oldest prediction
   // ------------------------------------------------------------------
   int unsigned rsp_wait = 0;

   task automatic report_field(input string field, input logic want, input logic got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %b, actual %b", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : check_rsp
      result_type  want;
      int unsigned hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_ticks.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result with nothing expected, actual %b%b%b", $time,
                        rsp_line_level, rsp_busy_res, rsp_rejected);
         end else begin
            want = expected_ticks.pop_front();
            report_field("line_level", want.line_level, rsp_line_level);
            report_field("busy_res", want.busy_res, rsp_busy_res);
            report_field("rejected", want.rejected, rsp_rejected);
         end
         ticks_checked++;
         // Every so often hold off long enough to back the block up
         hold = (ticks_checked % HOLD_EVERY == 0) ? LONG_HOLD : draw_wait();
         rsp_ready <= (hold == 0);
         rsp_wait  <= (hold == 0) ? 0 : hold - 1;
      end else if (!rsp_ready) begin
         if (rsp_wait != 0) rsp_wait <= rsp_wait - 1;
         else rsp_ready <= 1'b1;
      end
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue);
      pending_items.push_back('{cmd: cmd, red: red, green: green, blue: blue});
      items_queued++;
   endtask

   // Plain ticks; the color fields carry junk that the block must ignore
   task automatic queue_ticks(input int unsigned count);
      repeat (count) queue_item(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Busy ticks that a command would take under the present registers
   function automatic int unsigned transfer_len(input logic [CMD_W-1:0] cmd);
      int unsigned leds;
      int unsigned period;
      period = (csr_shadow.bit_period_ticks == '0) ? 1 : csr_shadow.bit_period_ticks;
      if (cmd == CMD_SEND) leds = 1;
      else leds = (csr_shadow.led_count > MAX_LEDS) ? MAX_LEDS : csr_shadow.led_count;
      return leds * BITS_PER_LED * period +
             ((cmd == CMD_SEND) ? 0 : csr_shadow.latch_low_ticks);
   endfunction

   // One command followed by ticks covering its transfer, with stray commands
   task automatic queue_transfer(input logic [CMD_W-1:0] cmd, input logic [7:0] red,
                                 input logic [7:0] green, input logic [7:0] blue,
                                 input int unsigned extra, input int unsigned noise_pct);
      int unsigned len;
      len = transfer_len(cmd);
      queue_item(cmd, red, green, blue);
      for (int unsigned i = 1; i < len + extra; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            queue_item(CMD_W'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                       8'($urandom));
         else
            queue_item(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   // Hold the sender until every offered item has come back
   task automatic drain_pipeline();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_ticks.size() != 0);
   endtask

   // Write one register; bits above its width carry junk
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      logic [15:0] junk;
      logic [15:0] data;
      junk = 16'($urandom);
      case (idx)
         CSR_LATCH_LOW: data = value;
         CSR_LED_COUNT: data = {junk[15:11], value[10:0]};
         default:       data = {junk[15:8], value[7:0]};
      endcase
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      reg_writes++;
      // Return once the shadow holds the new value
      @(negedge clock);
   endtask

   task automatic write_timing(input logic [7:0] zero_high, input logic [7:0] one_high,
                               input logic [7:0] period);
      write_reg(CSR_ZERO_HIGH, 16'(zero_high));
      write_reg(CSR_ONE_HIGH, 16'(one_high));
      write_reg(CSR_BIT_PERIOD, 16'(period));
   endtask

   // Small random settings keep transfers short; extremes now and then
   task automatic randomize_registers();
      logic [7:0] period;
      period = 8'($urandom_range(0, 10));
      write_reg(CSR_BIT_PERIOD, 16'(period));
      write_reg(CSR_ZERO_HIGH, ($urandom_range(0, 9) == 0) ? 16'hFF :
                               16'($urandom_range(0, period + 2)));
      write_reg(CSR_ONE_HIGH, ($urandom_range(0, 9) == 0) ? 16'd0 :
                              16'($urandom_range(0, period + 2)));
      write_reg(CSR_LATCH_LOW, ($urandom_range(0, 9) == 0) ? 16'd0 :
                               16'($urandom_range(1, 12)));
      write_reg(CSR_LED_COUNT, ($urandom_range(0, 9) == 0) ? 16'd3 :
                               16'($urandom_range(0, 2)));
      // Unused indexes must not disturb anything
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_IDX_W'(CSR_LED_COUNT + $urandom_range(1, 3)), 16'($urandom));
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int unsigned len;
      logic [CMD_W-1:0] cmd;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: first bits of a send with a stray command dropped as
      // busy, then a shorter period finishes the word
      queue_item(CMD_SEND, 8'h00, 8'hFF, 8'h55);
      queue_ticks(100);
      queue_item(CMD_CLEAR, 8'h00, 8'h00, 8'h00);
      queue_ticks(100);
      drain_pipeline();
      write_reg(CSR_BIT_PERIOD, 16'd2);
      queue_ticks(50);
      drain_pipeline();

      // Short bits; a command on the last busy tick is dropped, the next is taken
      write_timing(8'd1, 8'd3, 8'd4);
      write_reg(CSR_LATCH_LOW, 16'd5);
      write_reg(CSR_LED_COUNT, 16'd2);
      len = transfer_len(CMD_FILL);
      queue_item(CMD_FILL, 8'hFF, 8'h00, 8'hFF);
      queue_ticks(len - 2);
      queue_item(CMD_SEND, 8'h12, 8'h34, 8'h56);
      queue_transfer(CMD_SEND, 8'h5A, 8'hC3, 8'h0F, 3, 0);
      queue_transfer(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 3, 0);
      drain_pipeline();

      // High time at or above the period keeps the line high all bit
      write_timing(8'd6, 8'hFF, 8'd5);
      queue_transfer(CMD_SEND, 8'hA5, 8'h5A, 8'hC3, 2, 0);
      drain_pipeline();

      // Period of zero counts as one tick, then a period of one
      write_timing(8'd0, 8'd1, 8'd0);
      queue_transfer(CMD_SEND, 8'hFF, 8'h00, 8'hFF, 2, 0);
      drain_pipeline();
      write_timing(8'd2, 8'd0, 8'd1);
      queue_transfer(CMD_SEND, 8'h81, 8'h7E, 8'h3C, 2, 0);
      drain_pipeline();

      // No latch time: idle right after the last bit
      write_timing(8'd1, 8'd2, 8'd3);
      write_reg(CSR_LATCH_LOW, 16'd0);
      write_reg(CSR_LED_COUNT, 16'd1);
      queue_transfer(CMD_FILL, 8'hC0, 8'h03, 8'h18, 2, 0);
      drain_pipeline();

      // Empty chain: straight to the latch, or straight back to idle
      write_reg(CSR_LED_COUNT, 16'd0);
      write_reg(CSR_LATCH_LOW, 16'd3);
      queue_transfer(CMD_FILL, 8'h11, 8'h22, 8'h33, 2, 0);
      drain_pipeline();
      write_reg(CSR_LATCH_LOW, 16'd0);
      queue_transfer(CMD_CLEAR, 8'h44, 8'h55, 8'h66, 3, 0);
      drain_pipeline();

      // Shorten a running latch: it ends on the next tick
      write_reg(CSR_LED_COUNT, 16'd0);
      write_reg(CSR_LATCH_LOW, 16'hFFFF);
      queue_item(CMD_FILL, 8'h00, 8'h00, 8'h00);
      queue_ticks(20);
      drain_pipeline();
      write_reg(CSR_LATCH_LOW, 16'd4);
      queue_ticks(8);
      drain_pipeline();

      // Shorten a running bit period
      write_reg(CSR_LATCH_LOW, 16'd2);
      write_timing(8'd100, 8'd150, 8'd200);
      queue_item(CMD_SEND, 8'hE7, 8'h18, 8'hDB);
      queue_ticks(50);
      drain_pipeline();
      write_reg(CSR_BIT_PERIOD, 16'd3);
      queue_ticks(23 * 3 + 5);
      drain_pipeline();

      // Widest timing: one whole bit and part of the next at the longest period, then a short
      // period finishes the word
      write_timing(8'd128, 8'hFF, 8'hFF);
      queue_item(CMD_SEND, 8'h0F, 8'h4F, 8'h3C);
      queue_ticks(300);
      drain_pipeline();
      write_reg(CSR_BIT_PERIOD, 16'd2);
      queue_ticks(24 * 2 + 4);
      drain_pipeline();
      directed_items = items_queued;

      // Random phases: mostly whole transfers, some noise and broken ones
      while (items_queued - directed_items < RANDOM_ITEMS) begin
         randomize_registers();
         repeat ($urandom_range(2, 4)) begin
            cmd = CMD_W'($urandom_range(1, 3));
            case ($urandom_range(0, 5))
               0: begin
                  repeat ($urandom_range(1, 10))
                     queue_item(CMD_W'($urandom_range(0, 3)), 8'($urandom),
                                8'($urandom), 8'($urandom));
               end
               1: begin
                  // Change a register in the middle of a transfer
                  len = transfer_len(cmd);
                  queue_item(cmd, 8'($urandom), 8'($urandom), 8'($urandom));
                  queue_ticks($urandom_range(0, len));
                  drain_pipeline();
                  case ($urandom_range(0, 2))
                     0: write_reg(CSR_BIT_PERIOD, 16'($urandom_range(0, 10)));
                     1: write_reg(CSR_LATCH_LOW, 16'($urandom_range(0, 12)));
                     default: write_reg(CSR_ONE_HIGH, 16'($urandom_range(0, 12)));
                  endcase
                  queue_ticks(transfer_len(cmd) + 2);
               end
               default: begin
                  queue_transfer(cmd, 8'($urandom), 8'($urandom), 8'($urandom),
                                 $urandom_range(0, 3), 4);
               end
            endcase
         end
         drain_pipeline();
      end

      // Let any late result show up before judging the run
      drain_pipeline();
      repeat (END_WAIT) @(posedge clock);
      $display("Covered %0d ticks with %0d commands, %0d dropped while busy.",
               ticks_checked, commands_sent, busy_drops);
      $display("Used %0d register writes; %0d directed and %0d random items.",
               reg_writes, directed_items, items_queued - directed_items);
      if (mismatches == 0 && expected_ticks.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
